@@ hdl/middle_insert_queue_macros.svh @@
// assertion helpers for the middle insert queue checker
`ifndef MIDDLE_INSERT_QUEUE_MACROS_SVH
`define MIDDLE_INSERT_QUEUE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define MIQ_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("middle_insert_queue check failed");

// next-cycle implication, checked while out of reset
`define MIQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("middle_insert_queue check failed");

`endif

@@ hdl/miq_pkg.sv @@
`timescale 1ns / 1ps

package miq_pkg;

    localparam int FUNC_BITS   = 2;
    localparam int ID_BITS     = 16;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 11;

    // operation codes
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH_BACK = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH_MID  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_POP       = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [ID_BITS-1:0]   item_id;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0]     popped_id;
        logic [STATUS_BITS-1:0] status;
        logic [OCC_BITS-1:0]    occupancy;
    } rsp_t;

    // what every cell of the chain does in the update cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

endpackage

@@ hdl/miq_cell.sv @@
`timescale 1ns / 1ps

module miq_cell #(
    parameter int INDEX     = 0,
    parameter int POS_BITS  = 11,
    parameter int ITEM_BITS = 16
) (
    input  logic                     clk,
    input  miq_pkg::cell_op_t        cell_op,
    input  logic [POS_BITS-1:0]      tail_pos,
    input  logic [POS_BITS-1:0]      mid_pos,
    input  logic [ITEM_BITS-1:0]     cell_item,
    input  logic [ITEM_BITS-1:0]     left_data,
    input  logic [ITEM_BITS-1:0]     right_data,
    output logic [ITEM_BITS-1:0]     data
);
    import miq_pkg::*;

    localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(INDEX);

    logic [ITEM_BITS-1:0] data_reg;
    logic [ITEM_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cell_op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_APPEND:
            begin
                if (MY_POS == tail_pos)
                begin
                    data_next = cell_item;
                end
            end
            CELL_INSERT:
            begin
                // cells past the middle make room by taking from the left
                if (MY_POS == mid_pos)
                begin
                    data_next = cell_item;
                end
                else if (MY_POS > mid_pos)
                begin
                    data_next = left_data;
                end
            end
            CELL_SHIFT:
            begin
                data_next = right_data;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/miq_ctrl.sv @@
`timescale 1ns / 1ps

module miq_ctrl #(
    parameter int DEPTH     = 1024,
    parameter int ITEM_BITS = 16,
    parameter int CNT_BITS  = 11
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  miq_pkg::req_t          req,
    input  logic [ITEM_BITS-1:0]   head_data,
    output logic                   busy,
    output logic                   done,
    output miq_pkg::rsp_t          rsp,
    output miq_pkg::cell_op_t      cell_op,
    output logic [CNT_BITS-1:0]    tail_pos,
    output logic [CNT_BITS-1:0]    mid_pos,
    output logic [ITEM_BITS-1:0]   cell_item
);
    import miq_pkg::*;

    logic                pending_reg;
    logic                pending_next;
    logic                done_reg;
    logic                done_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    req_t                req_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic [ID_BITS-1:0]  popped;
    logic [STATUS_BITS-1:0] status;

    assign accept     = start && !pending_reg;
    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign empty      = (count_reg == '0);

    assign pending_next = accept;
    assign done_next    = pending_reg;

    always_comb
    begin
        cell_op    = CELL_HOLD;
        status     = STATUS_DONE;
        popped     = '0;
        count_next = count_reg;
        if (pending_reg)
        begin
            case (req_reg.func) inside
                FUNC_PUSH_BACK, FUNC_PUSH_MID:
                begin
                    if (full)
                    begin
                        status = STATUS_FULL;
                    end
                    else
                    begin
                        cell_op    = (req_reg.func == FUNC_PUSH_BACK) ? CELL_APPEND
                                                                       : CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_POP:
                begin
                    if (empty)
                    begin
                        status = STATUS_EMPTY;
                    end
                    else
                    begin
                        cell_op    = CELL_SHIFT;
                        popped     = ID_BITS'(head_data);
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    cell_op = CELL_HOLD;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next.popped_id = popped;
        rsp_next.status    = status;
        rsp_next.occupancy = OCC_BITS'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (pending_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy      = pending_reg;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign tail_pos  = count_reg;
    // middle position is ceil(count / 2)
    assign mid_pos   = (count_reg >> 1) + {{(CNT_BITS-1){1'b0}}, count_reg[0]};
    assign cell_item = ITEM_BITS'(req_reg.item_id);

endmodule

@@ hdl/middle_insert_queue.sv @@
`timescale 1ns / 1ps

// middle_insert_queue: fifo of item identifiers that also takes an item at its middle
// - request channel: start with req (func, item_id); taken at a clock edge where
//   start is high and busy is low
// - func push back appends at the tail, push middle inserts at position ceil(n/2),
//   pop front removes the head
// - result channel: done strobes for one cycle with rsp (popped_id, status,
//   occupancy); the receiver cannot stall, so each result must be taken that cycle
// - handshake: done is registered from busy, and rsp at the same edge; busy is high for the
//   single cycle in which the cell chain updates, and no request is taken then; a new
//   request may be taken while the previous result is still on rsp
// - storage is a chain of DEPTH cells, cell 0 holding the queue head; in the update
//   cycle every cell holds, loads the new item, shifts from its left neighbor
//   (middle insert) or from its right neighbor (pop), driven by a broadcast op
//   and the tail and middle positions
// - pop on an empty queue or push on a full queue reports its status and changes
//   nothing; func code 3 is a no-op with status done
// - reset clears the count and handshake state at once; cell contents are not
//   cleared and are never read before they are written
module middle_insert_queue #(
    parameter int DEPTH     = 1024,
    parameter int ITEM_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  miq_pkg::req_t  req,
    output logic           done,
    output miq_pkg::rsp_t  rsp
);
    import miq_pkg::*;

    // count runs from 0 up to DEPTH inclusive
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cell_op_t             cell_op;
    logic [CNT_BITS-1:0]  tail_pos;
    logic [CNT_BITS-1:0]  mid_pos;
    logic [ITEM_BITS-1:0] cell_item;
    logic [ITEM_BITS-1:0] cell_data [DEPTH];

    // control: request register, occupancy count, result register
    miq_ctrl #(
        .DEPTH     (DEPTH),
        .ITEM_BITS (ITEM_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .head_data (cell_data[0]),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cell_op   (cell_op),
        .tail_pos  (tail_pos),
        .mid_pos   (mid_pos),
        .cell_item (cell_item)
    );

    // the cell chain, head at index 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [ITEM_BITS-1:0] left_data;
        logic [ITEM_BITS-1:0] right_data;

        // first cell never takes from the left, so its left input is just the item
        if (g == 0)
        begin : g_first
            assign left_data = cell_item;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[g-1];
        end

        // last cell keeps its own value on a pop, which leaves it past the tail anyway
        if (g == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[g];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[g+1];
        end

        miq_cell #(
            .INDEX     (g),
            .POS_BITS  (CNT_BITS),
            .ITEM_BITS (ITEM_BITS)
        ) u_cell (
            .clk        (clk),
            .cell_op    (cell_op),
            .tail_pos   (tail_pos),
            .mid_pos    (mid_pos),
            .cell_item  (cell_item),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g])
        );
    end

endmodule

@@ hdl/miq_checker.sv @@
`timescale 1ns / 1ps

`include "middle_insert_queue_macros.svh"

module miq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input miq_pkg::rsp_t rsp
);
    import miq_pkg::*;

    // a taken request keeps the block busy for the next cycle
    `MIQ_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

    // busy lasts one cycle only
    `MIQ_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)

    // every result follows a taken request through the busy register and then the done register
    `MIQ_ASSERT_SAME(a_done_from_accept, done, $past(start && !busy, 2))

    // a failed pop reports an empty queue and no item
    `MIQ_ASSERT_SAME(a_empty_pop, done && (rsp.status == STATUS_EMPTY),
        (rsp.occupancy == '0) && (rsp.popped_id == '0))

endmodule

bind middle_insert_queue miq_checker u_miq_checker (.*);

@@ tb/sv/middle_insert_queue_tb.sv @@
`timescale 1ns / 1ps

module middle_insert_queue_tb;

    import miq_pkg::*;

    // queue size used by the block instance below
    localparam int QUEUE_DEPTH = 1024;
    localparam int FRONT_CAP   = (QUEUE_DEPTH + 1) / 2;
    localparam int BACK_CAP    = QUEUE_DEPTH / 2;

    // unused operation code, which the block treats as a no-op
    localparam logic [FUNC_BITS-1:0] FUNC_NOP = 2'd3;

    // random part: mixed traffic, then a fill to full, then a drain
    localparam int MIXED_ITEMS  = 150;
    localparam int RANDOM_ITEMS = 1330;
    localparam int DRAIN_MIN    = 40;
    localparam int FULL_PUSHES  = 12;

    // window of random requests sent back to back with no gaps
    localparam int NO_GAP_FIRST = 300;
    localparam int NO_GAP_LAST  = 600;

    // cycles with nothing taken before the run is declared hung
    localparam int STALL_LIMIT = 1000;

    // two-half queue model plus the list of responses still owed by the block
    class miq_scoreboard;
        logic [ID_BITS-1:0] front_store [FRONT_CAP];
        logic [ID_BITS-1:0] back_store [BACK_CAP];
        int front_head;
        int front_count;
        int back_head;
        int back_count;
        rsp_t expected_rsp[$];
        int errors;

        function new();
            front_head  = 0;
            front_count = 0;
            back_head   = 0;
            back_count  = 0;
            errors      = 0;
        endfunction

        task report(string what);
            $display("[%0t] middle_insert_queue mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void front_append(logic [ID_BITS-1:0] v);
            front_store[(front_head + front_count) % FRONT_CAP] = v;
            front_count++;
        endfunction

        function void back_append(logic [ID_BITS-1:0] v);
            back_store[(back_head + back_count) % BACK_CAP] = v;
            back_count++;
        endfunction

        function logic [ID_BITS-1:0] back_take();
            logic [ID_BITS-1:0] v;
            v          = back_store[back_head];
            back_head  = (back_head + 1) % BACK_CAP;
            back_count--;
            return v;
        endfunction

        // apply one request to the model and return the response it should give
        function rsp_t step_queue(req_t r);
            rsp_t o;
            int total;
            o     = '0;
            total = front_count + back_count;
            case (r.func) inside
                FUNC_PUSH_BACK, FUNC_PUSH_MID:
                begin
                    if (total >= QUEUE_DEPTH)
                    begin
                        o.status = STATUS_FULL;
                    end
                    else if (r.func == FUNC_PUSH_BACK)
                    begin
                        if (front_count != back_count)
                        begin
                            back_append(r.item_id);
                        end
                        else if (back_count == 0)
                        begin
                            front_append(r.item_id);
                        end
                        else
                        begin
                            front_append(back_take());
                            back_append(r.item_id);
                        end
                    end
                    else if (front_count == back_count)
                    begin
                        front_append(r.item_id);
                    end
                    else
                    begin
                        back_head = (back_head + BACK_CAP - 1) % BACK_CAP;
                        back_store[back_head] = r.item_id;
                        back_count++;
                    end
                end
                FUNC_POP:
                begin
                    if (total == 0)
                    begin
                        o.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        o.popped_id = front_store[front_head];
                        front_head  = (front_head + 1) % FRONT_CAP;
                        front_count--;
                        if (back_count > front_count)
                            front_append(back_take());
                    end
                end
                default:
                begin
                end
            endcase
            o.status    = (o.status == '0) ? STATUS_DONE : o.status;
            o.occupancy = OCC_BITS'(front_count + back_count);
            return o;
        endfunction

        function void note_request(req_t r);
            rsp_t owed;
            owed         = step_queue(r);
            expected_rsp = {expected_rsp, owed};
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                report($sformatf("response with none outstanding: %p", got));
                return;
            end
            want = expected_rsp[0];
            expected_rsp.delete(0);
            if (got.popped_id !== want.popped_id)
                report($sformatf("popped_id %h, want %h", got.popped_id, want.popped_id));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
        endtask

        function int outstanding();
            return expected_rsp.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    miq_scoreboard sb;

    // fill level as the request stream sees it, used only to steer the stimulus
    int planned_fill;
    // index of the current random request, for the no-gap window
    int rand_index;
    int stall_cycles;

    middle_insert_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .ITEM_BITS (ID_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // one observer for both channels, so a request is always noted before any
    // response that lands on the same edge is checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(req);
            if (done)
                sb.check_result(rsp);
        end
    end

    // hang detector: counts edges at which neither a request nor a response moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("middle_insert_queue_tb: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // hold start with this request until the block takes it, then track the
    // fill level and maybe leave a gap before the next one
    task send(req_t r, bit allow_gap);
        int gap;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        case (r.func) inside
            FUNC_PUSH_BACK, FUNC_PUSH_MID:
                if (planned_fill < QUEUE_DEPTH)
                    planned_fill++;
            FUNC_POP:
                if (planned_fill > 0)
                    planned_fill--;
            default:
            begin
            end
        endcase
        // roughly one request in six is followed by an idle gap
        if (allow_gap && $urandom_range(99) < 16)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task send_op(logic [FUNC_BITS-1:0] f, logic [ID_BITS-1:0] id);
        req_t r;
        r.func    = f;
        r.item_id = id;
        send(r, 1'b1);
    endtask

    // random request: percentages for push back, push middle and pop; the
    // remainder is the unused code
    task send_random(int pct_back, int pct_mid, int pct_pop);
        req_t r;
        int roll;
        roll      = $urandom_range(99);
        r.item_id = ID_BITS'($urandom);
        if (roll < pct_back)
            r.func = FUNC_PUSH_BACK;
        else if (roll < pct_back + pct_mid)
            r.func = FUNC_PUSH_MID;
        else if (roll < pct_back + pct_mid + pct_pop)
            r.func = FUNC_POP;
        else
            r.func = FUNC_NOP;
        send(r, !(rand_index >= NO_GAP_FIRST && rand_index < NO_GAP_LAST));
        rand_index++;
    endtask

    // sender holds off until every owed response has come back
    task wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    initial
    begin
        int drained;
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        planned_fill = 0;
        rand_index   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, extreme ids, both middle-insert placements,
        // push back with equal nonempty halves, the unused code
        send_op(FUNC_POP,       16'h1234);
        send_op(FUNC_PUSH_BACK, 16'hFFFF);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'hFFFF);
        send_op(FUNC_PUSH_MID,  16'h0000);
        send_op(FUNC_PUSH_MID,  16'hFFFF);
        send_op(FUNC_PUSH_MID,  16'h5555);
        send_op(FUNC_PUSH_BACK, 16'hAAAA);
        send_op(FUNC_PUSH_BACK, 16'h0001);
        send_op(FUNC_PUSH_MID,  16'h8000);
        send_op(FUNC_NOP,       16'h7FFF);
        send_op(FUNC_PUSH_BACK, 16'h00FF);
        send_op(FUNC_PUSH_MID,  16'hFF00);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_PUSH_MID,  16'h0F0F);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        send_op(FUNC_POP,       16'h0000);
        wait_drained();

        // mixed traffic starting from an empty queue, with pushes outweighing pops
        repeat (MIXED_ITEMS)
            send_random(35, 25, 38);
        wait_drained();

        // fill to full with mostly pushes, then push into the full queue
        while (planned_fill < QUEUE_DEPTH)
            send_random(60, 35, 5);
        repeat (FULL_PUSHES)
            send_random(50, 45, 5);

        // drain with mostly pops, reordering the contents on the way down
        drained = 0;
        while (rand_index < RANDOM_ITEMS || drained < DRAIN_MIN)
        begin
            send_random(15, 13, 70);
            drained++;
        end
        start <= 1'b0;

        // let the last responses come back, plus a few idle cycles
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (sb.errors == 0)
            $display("middle_insert_queue_tb: done, clean");
        else
            $display("middle_insert_queue_tb: done, errors");
        $finish;
    end

endmodule
